>>> rtl/ebalu_pkg.sv
// Package with the operation codes, status flag positions and beat types of the ALU.
package ebalu_pkg;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADC  = 5'd1,
		OP_SUB  = 5'd2,
		OP_SBC  = 5'd3,
		OP_CP   = 5'd4,
		OP_CPC  = 5'd5,
		OP_AND  = 5'd6,
		OP_OR   = 5'd7,
		OP_EOR  = 5'd8,
		OP_COM  = 5'd9,
		OP_NEG  = 5'd10,
		OP_INC  = 5'd11,
		OP_DEC  = 5'd12,
		OP_LSR  = 5'd13,
		OP_ASR  = 5'd14,
		OP_ROR  = 5'd15,
		OP_SWAP = 5'd16,
		OP_ADIW = 5'd17,
		OP_SBIW = 5'd18,
		OP_BSET = 5'd19,
		OP_BCLR = 5'd20,
		OP_BST  = 5'd21,
		OP_BLD  = 5'd22,
		OP_WSR  = 5'd23
	} op_t;

	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_V = 3;
	localparam int unsigned FLAG_S = 4;
	localparam int unsigned FLAG_H = 5;
	localparam int unsigned FLAG_T = 6;

	localparam logic [7:0] BYTE_SIGN  = 8'h80;
	localparam logic [7:0] BYTE_MAXP  = 8'h7F;

	typedef struct packed {
		logic [4:0]  operation;
		logic [15:0] operand_d;
		logic [7:0]  operand_r;
		logic [2:0]  bit_index;
	} alu_in_t;

	typedef struct packed {
		logic [15:0] result;
		logic        write_back;
		logic [7:0]  status;
	} alu_out_t;

endpackage

>>> rtl/ebalu_core.sv
// Combinational datapath that computes the result and the next status byte for one beat.
module ebalu_core (
	input  ebalu_pkg::alu_in_t  in_item,
	input  logic [7:0]          sreg,
	output ebalu_pkg::alu_out_t out_item
);

	logic [7:0]  d;
	logic [7:0]  r;
	logic [15:0] word;
	logic [15:0] k16;
	logic [7:0]  bm;
	logic        cin;
	logic [7:0]  sub_a;
	logic [7:0]  sub_b;
	logic [8:0]  add_sum;
	logic [8:0]  sub_diff;
	logic [15:0] wsum;
	logic [15:0] wdiff;
	ebalu_pkg::op_t op;

	assign op   = ebalu_pkg::op_t'(in_item.operation);
	assign word = in_item.operand_d;
	assign d    = in_item.operand_d[7:0];
	assign r    = in_item.operand_r;
	assign k16  = {10'd0, in_item.operand_r[5:0]};
	assign bm   = 8'd1 << in_item.bit_index;

	assign cin = ((op == ebalu_pkg::OP_ADC) || (op == ebalu_pkg::OP_SBC) ||
		(op == ebalu_pkg::OP_CPC)) ? sreg[ebalu_pkg::FLAG_C] : 1'b0;
	assign sub_a = (op == ebalu_pkg::OP_NEG) ? 8'd0 : d;
	assign sub_b = (op == ebalu_pkg::OP_NEG) ? d : r;

	assign add_sum  = {1'b0, d} + {1'b0, r} + {8'd0, cin};
	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b} - {8'd0, cin};
	assign wsum     = word + k16;
	assign wdiff    = word - k16;

	always_comb begin
		logic [7:0]  res8;
		logic [15:0] res16;
		logic [7:0]  st;
		logic        wb;
		logic        v;
		logic        c;
		logic        chain;
		logic        a15;
		logic        r15;
		res8  = 8'd0;
		res16 = 16'd0;
		st    = sreg;
		wb    = 1'b0;
		v     = 1'b0;
		c     = 1'b0;
		chain = 1'b0;
		a15   = word[15];
		r15   = 1'b0;
		unique case (op)
			ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
				res8 = add_sum[7:0];
				v = (d[7] & r[7] & ~res8[7]) | (~d[7] & ~r[7] & res8[7]);
				st[ebalu_pkg::FLAG_H] = (d[3] & r[3]) | (r[3] & ~res8[3]) | (~res8[3] & d[3]);
				st[ebalu_pkg::FLAG_C] = add_sum[8];
				st[ebalu_pkg::FLAG_N] = res8[7];
				st[ebalu_pkg::FLAG_V] = v;
				st[ebalu_pkg::FLAG_S] = res8[7] ^ v;
				st[ebalu_pkg::FLAG_Z] = (res8 == 8'd0);
				wb = 1'b1;
			end
			ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP, ebalu_pkg::OP_CPC,
			ebalu_pkg::OP_NEG: begin
				res8 = sub_diff[7:0];
				chain = (op == ebalu_pkg::OP_SBC) || (op == ebalu_pkg::OP_CPC);
				v = (sub_a[7] & ~sub_b[7] & ~res8[7]) | (~sub_a[7] & sub_b[7] & res8[7]);
				st[ebalu_pkg::FLAG_H] = (~sub_a[3] & sub_b[3]) | (sub_b[3] & res8[3]) |
					(res8[3] & ~sub_a[3]);
				st[ebalu_pkg::FLAG_C] = sub_diff[8];
				st[ebalu_pkg::FLAG_N] = res8[7];
				st[ebalu_pkg::FLAG_V] = v;
				st[ebalu_pkg::FLAG_S] = res8[7] ^ v;
				st[ebalu_pkg::FLAG_Z] = (res8 == 8'd0) & (~chain | sreg[ebalu_pkg::FLAG_Z]);
				wb = (op != ebalu_pkg::OP_CP) && (op != ebalu_pkg::OP_CPC);
			end
			ebalu_pkg::OP_AND, ebalu_pkg::OP_OR, ebalu_pkg::OP_EOR, ebalu_pkg::OP_COM: begin
				priority case (op)
					ebalu_pkg::OP_AND: res8 = d & r;
					ebalu_pkg::OP_OR:  res8 = d | r;
					ebalu_pkg::OP_EOR: res8 = d ^ r;
					default:           res8 = ~d;
				endcase
				st[ebalu_pkg::FLAG_N] = res8[7];
				st[ebalu_pkg::FLAG_V] = 1'b0;
				st[ebalu_pkg::FLAG_S] = res8[7];
				st[ebalu_pkg::FLAG_Z] = (res8 == 8'd0);
				if (op == ebalu_pkg::OP_COM) begin
					st[ebalu_pkg::FLAG_C] = 1'b1;
				end
				wb = 1'b1;
			end
			ebalu_pkg::OP_INC, ebalu_pkg::OP_DEC: begin
				if (op == ebalu_pkg::OP_INC) begin
					res8 = d + 8'd1;
					v = (res8 == ebalu_pkg::BYTE_SIGN);
				end else begin
					res8 = d - 8'd1;
					v = (res8 == ebalu_pkg::BYTE_MAXP);
				end
				st[ebalu_pkg::FLAG_N] = res8[7];
				st[ebalu_pkg::FLAG_V] = v;
				st[ebalu_pkg::FLAG_S] = res8[7] ^ v;
				st[ebalu_pkg::FLAG_Z] = (res8 == 8'd0);
				wb = 1'b1;
			end
			ebalu_pkg::OP_LSR, ebalu_pkg::OP_ASR, ebalu_pkg::OP_ROR: begin
				priority case (op)
					ebalu_pkg::OP_LSR: res8 = {1'b0, d[7:1]};
					ebalu_pkg::OP_ASR: res8 = {d[7], d[7:1]};
					default:           res8 = {sreg[ebalu_pkg::FLAG_C], d[7:1]};
				endcase
				c = d[0];
				v = res8[7] ^ c;
				st[ebalu_pkg::FLAG_C] = c;
				st[ebalu_pkg::FLAG_N] = res8[7];
				st[ebalu_pkg::FLAG_V] = v;
				st[ebalu_pkg::FLAG_S] = res8[7] ^ v;
				st[ebalu_pkg::FLAG_Z] = (res8 == 8'd0);
				wb = 1'b1;
			end
			ebalu_pkg::OP_SWAP: begin
				res8 = {d[3:0], d[7:4]};
				wb = 1'b1;
			end
			ebalu_pkg::OP_ADIW, ebalu_pkg::OP_SBIW: begin
				if (op == ebalu_pkg::OP_ADIW) begin
					res16 = wsum;
					r15 = res16[15];
					v = ~a15 & r15;
					c = a15 & ~r15;
				end else begin
					res16 = wdiff;
					r15 = res16[15];
					v = a15 & ~r15;
					c = ~a15 & r15;
				end
				st[ebalu_pkg::FLAG_C] = c;
				st[ebalu_pkg::FLAG_N] = r15;
				st[ebalu_pkg::FLAG_V] = v;
				st[ebalu_pkg::FLAG_S] = r15 ^ v;
				st[ebalu_pkg::FLAG_Z] = (res16 == 16'd0);
				wb = 1'b1;
			end
			ebalu_pkg::OP_BSET: st = sreg | bm;
			ebalu_pkg::OP_BCLR: st = sreg & ~bm;
			ebalu_pkg::OP_BST:  st[ebalu_pkg::FLAG_T] = |(d & bm);
			ebalu_pkg::OP_BLD: begin
				res8 = sreg[ebalu_pkg::FLAG_T] ? (d | bm) : (d & ~bm);
				wb = 1'b1;
			end
			ebalu_pkg::OP_WSR:  st = r;
			default: begin
				st = sreg;
			end
		endcase
		if ((op == ebalu_pkg::OP_ADIW) || (op == ebalu_pkg::OP_SBIW)) begin
			out_item.result = res16;
		end else begin
			out_item.result = {8'd0, res8};
		end
		out_item.write_back = wb;
		out_item.status = st;
	end

endmodule

>>> rtl/eight_bit_alu_with_status_flags.sv
// Top level of the 8-bit ALU with its status register, input register and result register.
// The unit takes one beat per clock cycle when the output side is not stalled; an accepted
// beat passes through the input register and then the result register. A beat is
// registered, then the datapath computes the result and the new status byte against the
// status register, which is updated as the beat moves into the result register, so every
// operation sees the flags of the one before it. Both registers hold under back pressure,
// and the status register resets to zero.
module eight_bit_alu_with_status_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  operation,
	input  logic [15:0] operand_d,
	input  logic [7:0]  operand_r,
	input  logic [2:0]  bit_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result,
	output logic        write_back,
	output logic [7:0]  status
);

	ebalu_pkg::alu_in_t  item_s1;
	ebalu_pkg::alu_out_t item_s2;
	ebalu_pkg::alu_out_t core_out;
	logic                valid_s1;
	logic                valid_s2;
	logic [7:0]          sreg_q;
	logic                adv_s2;
	logic                adv_s1;

	assign adv_s2   = ~valid_s2 | out_ready;
	assign adv_s1   = valid_s1 & adv_s2;
	assign in_ready = ~valid_s1 | adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sreg_q   <= 8'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				sreg_q <= core_out.status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.operation <= operation;
			item_s1.operand_d <= operand_d;
			item_s1.operand_r <= operand_r;
			item_s1.bit_index <= bit_index;
		end
		if (adv_s1) begin
			item_s2 <= core_out;
		end
	end

	ebalu_core u_core (
		.in_item  (item_s1),
		.sreg     (sreg_q),
		.out_item (core_out)
	);

	assign out_valid  = valid_s2;
	assign result     = item_s2.result;
	assign write_back = item_s2.write_back;
	assign status     = item_s2.status;

endmodule
